[src/awm_pkg.sv]
// shared types and constants of the max-weight assignment solver
// no dependencies
package awm_pkg;

  localparam int MAX_SIZE_DEF    = 16;
  localparam int WEIGHT_BITS_DEF = 16;
  localparam logic [4:0] SIZE_RESET = 5'd16;
  localparam int signed TOTAL_MAX = 524287;
  localparam int signed TOTAL_MIN = -524288;

  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef struct packed {
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [15:0] weight_value;
    logic               last_element;
  } awm_item_t;

  typedef struct packed {
    logic [3:0]         out_row;
    logic [3:0]         matched_col;
    logic signed [19:0] total_weight;
    logic               status;
    logic               last_result;
  } awm_result_t;

endpackage

[src/awm_wmem.sv]
// weight matrix memory, one write port and one registered read port
// depends on nothing
module awm_wmem #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [DW-1:0] wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [DW-1:0] rdata_o
);

  logic signed [DW-1:0] mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[src/awm_core.sv]
// kuhn-munkres sequencer: loads weights, solves, emits one result per row
// depends on awm_pkg and awm_wmem
module awm_core import awm_pkg::*; #(
  parameter int MAX_SIZE    = MAX_SIZE_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  awm_item_t   item_i,
  input  logic [4:0]  size_i,
  output logic        busy_o,
  output logic        res_valid_o,
  output awm_result_t res_o
);

  localparam int IW = $clog2(MAX_SIZE);
  localparam int NW = IW + 1;
  localparam int AW = 2 * IW;
  localparam int LW = WEIGHT_BITS + IW + 4;
  localparam int SW = LW + 2;
  localparam int TW = WEIGHT_BITS + IW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_MX_RD, S_MX_CK, S_X_START, S_FP_TOP, S_FP_CK, S_AUG,
    S_SL_RD, S_SL_CK, S_UPD, S_TOT_RD, S_TOT_CK, S_OUT
  } state_e;

  state_e state_q;
  logic [NW-1:0] n_q, x_q, ri_q, ci_q;
  logic [IW-1:0] sp_q, k_q;
  logic signed [WEIGHT_BITS-1:0] max_q;
  logic found_q, ok_q;
  logic signed [SW-1:0] d_q;
  logic signed [TW-1:0] tot_q;
  logic [MAX_SIZE-1:0] rv_q, cv_q, rm_q, cm_q;
  logic res_valid_q;
  awm_result_t res_q;

  logic signed [LW-1:0] rl_q [MAX_SIZE];
  logic signed [LW-1:0] cl_q [MAX_SIZE];
  logic [IW-1:0] rp_q [MAX_SIZE];
  logic [IW-1:0] cp_q [MAX_SIZE];
  logic [IW-1:0] stk_row_q [MAX_SIZE];
  logic [IW-1:0] stk_col_q [MAX_SIZE];
  logic [NW-1:0] stk_nxt_q [MAX_SIZE];

  logic                          mem_we;
  logic [AW-1:0]                 waddr, raddr;
  logic signed [WEIGHT_BITS-1:0] wdata, rdata;
  logic [IW+3:0]                 row_ext, col_ext;
  logic                          in_range;

  logic [IW-1:0] cur_r, cur_j, ri_ix, ci_ix;
  logic [NW-1:0] cur_nxt;
  logic signed [SW-1:0] edge_sum, slack;
  logic signed [WEIGHT_BITS-1:0] mx_new;
  logic signed [19:0] tot_sat;
  logic [NW-1:0] n_clamp;
  logic ci_wrap;

  assign row_ext  = {{IW{1'b0}}, item_i.row_index};
  assign col_ext  = {{IW{1'b0}}, item_i.col_index};
  assign in_range = (int'(item_i.row_index) < MAX_SIZE) && (int'(item_i.col_index) < MAX_SIZE);
  assign mem_we   = accept_i && in_range;
  assign waddr    = {row_ext[IW-1:0], col_ext[IW-1:0]};
  assign wdata    = WEIGHT_BITS'(item_i.weight_value);

  assign cur_r   = stk_row_q[sp_q];
  assign cur_nxt = stk_nxt_q[sp_q];
  assign cur_j   = cur_nxt[IW-1:0];
  assign ri_ix   = ri_q[IW-1:0];
  assign ci_ix   = ci_q[IW-1:0];
  assign ci_wrap = (ci_q + NW'(1)) == n_q;

  always_comb begin
    case (state_q)
      S_MX_RD:  raddr = {ri_ix, ci_ix};
      S_FP_TOP: raddr = {cur_r, cur_j};
      S_SL_RD:  raddr = {ri_ix, ci_ix};
      S_TOT_RD: raddr = {ri_ix, rp_q[ri_ix]};
      default:  raddr = {ri_ix, ci_ix};
    endcase
  end

  awm_wmem #(.AW(AW), .DW(WEIGHT_BITS)) u_wmem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign edge_sum = SW'(rl_q[cur_r]) + SW'(cl_q[cur_j]);
  assign slack    = SW'(rl_q[ri_ix]) + SW'(cl_q[ci_ix]) - SW'(rdata);
  assign mx_new   = (ci_q == '0 || rdata > max_q) ? rdata : max_q;

  always_comb begin
    if (tot_q > TOTAL_MAX) begin
      tot_sat = 20'(TOTAL_MAX);
    end else if (tot_q < TOTAL_MIN) begin
      tot_sat = 20'(TOTAL_MIN);
    end else begin
      tot_sat = 20'(tot_q);
    end
  end

  always_comb begin
    if (size_i == '0) begin
      n_clamp = NW'(1);
    end else if (int'(size_i) > MAX_SIZE) begin
      n_clamp = NW'(MAX_SIZE);
    end else begin
      n_clamp = NW'(size_i);
    end
  end

  // control state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      x_q         <= '0;
      ri_q        <= '0;
      ci_q        <= '0;
      sp_q        <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      rv_q        <= '0;
      cv_q        <= '0;
      rm_q        <= '0;
      cm_q        <= '0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (accept_i && item_i.last_element) begin
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          n_q     <= n_clamp;
          ok_q    <= 1'b1;
          rm_q    <= '0;
          cm_q    <= '0;
          ri_q    <= '0;
          ci_q    <= '0;
          state_q <= S_MX_RD;
        end
        S_MX_RD: state_q <= S_MX_CK;
        S_MX_CK: begin
          if (ci_wrap) begin
            ci_q <= '0;
            if ((ri_q + NW'(1)) == n_q) begin
              x_q     <= '0;
              state_q <= S_X_START;
            end else begin
              ri_q    <= ri_q + NW'(1);
              state_q <= S_MX_RD;
            end
          end else begin
            ci_q    <= ci_q + NW'(1);
            state_q <= S_MX_RD;
          end
        end
        S_X_START: begin
          rv_q    <= MAX_SIZE'(1) << x_q[IW-1:0];
          cv_q    <= '0;
          sp_q    <= '0;
          state_q <= S_FP_TOP;
        end
        S_FP_TOP: begin
          if (cur_nxt >= n_q) begin
            if (sp_q == '0) begin
              ri_q    <= '0;
              ci_q    <= '0;
              found_q <= 1'b0;
              state_q <= S_SL_RD;
            end else begin
              sp_q <= sp_q - IW'(1);
            end
          end else if (!cv_q[cur_j]) begin
            state_q <= S_FP_CK;
          end
        end
        S_FP_CK: begin
          state_q <= S_FP_TOP;
          if (edge_sum == SW'(rdata)) begin
            cv_q[cur_j] <= 1'b1;
            if (!cm_q[cur_j]) begin
              k_q     <= sp_q;
              state_q <= S_AUG;
            end else if (!(int'(sp_q) + 1 >= MAX_SIZE || NW'(cp_q[cur_j]) >= n_q)) begin
              sp_q               <= sp_q + IW'(1);
              rv_q[cp_q[cur_j]]  <= 1'b1;
            end
          end
        end
        S_AUG: begin
          rm_q[stk_row_q[k_q]] <= 1'b1;
          cm_q[stk_col_q[k_q]] <= 1'b1;
          if (k_q == '0) begin
            if ((x_q + NW'(1)) == n_q) begin
              ri_q    <= '0;
              state_q <= S_TOT_RD;
            end else begin
              x_q     <= x_q + NW'(1);
              state_q <= S_X_START;
            end
          end else begin
            k_q <= k_q - IW'(1);
          end
        end
        S_SL_RD: begin
          if (ri_q >= n_q) begin
            ri_q <= '0;
            if (!found_q) begin
              ok_q    <= 1'b0;
              state_q <= S_OUT;
            end else begin
              state_q <= S_UPD;
            end
          end else if (!rv_q[ri_ix] || cv_q[ci_ix]) begin
            ci_q <= ci_wrap ? '0 : ci_q + NW'(1);
            ri_q <= ci_wrap ? ri_q + NW'(1) : ri_q;
          end else begin
            state_q <= S_SL_CK;
          end
        end
        S_SL_CK: begin
          found_q <= 1'b1;
          ci_q    <= ci_wrap ? '0 : ci_q + NW'(1);
          ri_q    <= ci_wrap ? ri_q + NW'(1) : ri_q;
          state_q <= S_SL_RD;
        end
        S_UPD: state_q <= S_X_START;
        S_TOT_RD: begin
          if (ri_q >= n_q) begin
            ri_q    <= '0;
            state_q <= S_OUT;
          end else if (rm_q[ri_ix]) begin
            state_q <= S_TOT_CK;
          end else begin
            ri_q <= ri_q + NW'(1);
          end
        end
        S_TOT_CK: begin
          ri_q    <= ri_q + NW'(1);
          state_q <= S_TOT_RD;
        end
        S_OUT: begin
          res_valid_q           <= 1'b1;
          res_q.out_row         <= 4'(ri_q);
          res_q.matched_col     <= (ok_q && rm_q[ri_ix]) ? 4'(rp_q[ri_ix]) : 4'd0;
          res_q.total_weight    <= ok_q ? tot_sat : 20'sd0;
          res_q.status          <= !ok_q;
          res_q.last_result     <= (ri_q + NW'(1)) == n_q;
          if ((ri_q + NW'(1)) == n_q) begin
            state_q <= S_IDLE;
          end else begin
            ri_q <= ri_q + NW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // labels, partners, search stack and accumulators
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_INIT: begin
        for (int i = 0; i < MAX_SIZE; i++) begin
          rl_q[i] <= '0;
          cl_q[i] <= '0;
        end
      end
      S_MX_CK: begin
        max_q <= mx_new;
        if (ci_wrap) begin
          rl_q[ri_ix] <= LW'(mx_new);
        end
      end
      S_X_START: begin
        stk_row_q[0] <= x_q[IW-1:0];
        stk_nxt_q[0] <= '0;
      end
      S_FP_TOP: begin
        if (cur_nxt < n_q && cv_q[cur_j]) begin
          stk_nxt_q[sp_q] <= cur_nxt + NW'(1);
        end
      end
      S_FP_CK: begin
        stk_nxt_q[sp_q] <= cur_nxt + NW'(1);
        if (edge_sum == SW'(rdata)) begin
          stk_col_q[sp_q] <= cur_j;
          if (cm_q[cur_j] && !(int'(sp_q) + 1 >= MAX_SIZE || NW'(cp_q[cur_j]) >= n_q)) begin
            stk_row_q[sp_q + IW'(1)] <= cp_q[cur_j];
            stk_nxt_q[sp_q + IW'(1)] <= '0;
          end
        end
      end
      S_AUG: begin
        rp_q[stk_row_q[k_q]] <= stk_col_q[k_q];
        cp_q[stk_col_q[k_q]] <= stk_row_q[k_q];
        tot_q                <= '0;
      end
      S_SL_CK: begin
        if (!found_q || slack < d_q) begin
          d_q <= slack;
        end
      end
      S_UPD: begin
        for (int i = 0; i < MAX_SIZE; i++) begin
          if (rv_q[i]) begin
            rl_q[i] <= LW'(SW'(rl_q[i]) - d_q);
          end
          if (cv_q[i]) begin
            cl_q[i] <= LW'(SW'(cl_q[i]) + d_q);
          end
        end
      end
      S_TOT_CK: tot_q <= tot_q + TW'(rdata);
      default: ;
    endcase
  end

  assign busy_o      = (state_q != S_IDLE) || res_valid_q;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[src/max_weight_assignment_solver.sv]
// after the last element the row maxima are found, then each search round runs a path
// search and, with no path, a slack scan and label update; every weight read goes
// through the single weight read port
// then the totals are summed, then n results one per cycle; the receiver cannot stall
// loading takes one element per cycle; busy drops the cycle after the last result
// reset clears control state and sets size_in_use to 16; no clearing pass; uses awm_pkg
module max_weight_assignment_solver import awm_pkg::*; #(
  parameter int MAX_SIZE    = MAX_SIZE_DEF,
  parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  awm_item_t   item_i,
  output logic        res_valid_o,
  output awm_result_t res_o
);

  logic [4:0] size_q;
  logic       accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_SIZE_IN_USE) begin
      size_q <= pwdata[4:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? {27'd0, size_q} : 32'd0;
  assign accept = start && !busy;

  awm_core #(.MAX_SIZE(MAX_SIZE), .WEIGHT_BITS(WEIGHT_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (item_i),
    .size_i      (size_q),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

[src/awm_checker.sv]
// port-level checks of the solver, bound to the top level
// depends on awm_pkg and max_weight_assignment_solver
module awm_props import awm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input awm_item_t   item_i,
  input logic        res_valid_o,
  input awm_result_t res_o
);

  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result outside solve");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last_result |=> !res_valid_o) else $error("result after last");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last_result |=> res_valid_o) else $error("gap in results");

  a_load_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !item_i.last_element |=> !busy) else $error("load stalled");

  a_total_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(res_valid_o) && !$past(res_o.last_result)
      |-> res_o.total_weight == $past(res_o.total_weight)) else $error("total changed");

endmodule

bind max_weight_assignment_solver awm_props u_awm_props (.*);
